@@ hw/rtl/ati_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_pkg: shared constants, types and tables for the tilt angle pipeline
// Angle table, pipeline payload types and fixed-point widths.
// ----------------------------------------------------------------------------
package ati_pkg;

  localparam int CordicSteps   = 16;
  localparam int AngleFracBits = 8;
  localparam int AccFrac       = 24;
  localparam int DegRight      = 90;

  // squares and root
  localparam int SumW   = 34;           // a*a + b*b, unsigned
  localparam int RadW   = SumW + 16;    // sum << 16
  localparam int RootW  = RadW / 2;     // 25 bits, value below 2^24
  // CORDIC datapath: x grows by at most ~1.65, y stays bounded
  localparam int CordW  = 30;
  localparam int AccW   = 32;

  localparam int RoundSh = AccFrac - AngleFracBits;
  localparam logic signed [AccW-1:0] AccFull = AccW'(DegRight) <<< AccFrac;
  localparam logic signed [AccW-1:0] OutLim  = AccW'(DegRight) <<< AngleFracBits;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // one CORDIC lane in flight
  typedef struct packed {
    cord_t x;
    cord_t y;
    acc_t  acc;
    logic  zero_den;
  } lane_t;

  // atan(2^-i) in units of 2^-24 degree
  function automatic acc_t atan_tab(input logic [4:0] i);
    acc_t v;
    case (i)
      5'd0:  v = 754974720;  5'd1:  v = 445687602;
      5'd2:  v = 235489088;  5'd3:  v = 119537938;
      5'd4:  v = 60000934;   5'd5:  v = 30029717;
      5'd6:  v = 15018523;   5'd7:  v = 7509720;
      5'd8:  v = 3754917;    5'd9:  v = 1877466;
      5'd10: v = 938734;     5'd11: v = 469367;
      5'd12: v = 234684;     5'd13: v = 117342;
      5'd14: v = 58671;      5'd15: v = 29335;
      5'd16: v = 14668;      5'd17: v = 7334;
      5'd18: v = 3667;       5'd19: v = 1833;
      5'd20: v = 917;        5'd21: v = 458;
      5'd22: v = 229;        5'd23: v = 115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/ati_sqrt_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_sqrt_stage: one pipelined step of the restoring square root
// Retires one result bit per stage; the remainder and radicand travel along.
// ----------------------------------------------------------------------------
module ati_sqrt_stage (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ati_pkg::RadW-1:0]      rad_in,
  input  logic [ati_pkg::RootW-1:0]     root_in,
  input  logic [ati_pkg::RootW+1:0]     rem_in,
  output logic [ati_pkg::RadW-1:0]      rad_out,
  output logic [ati_pkg::RootW-1:0]     root_out,
  output logic [ati_pkg::RootW+1:0]     rem_out
);
  logic [ati_pkg::RootW+1:0] rem_sh;
  logic [ati_pkg::RootW+1:0] trial;
  logic [ati_pkg::RootW-1:0] root_nxt;
  logic [ati_pkg::RootW+1:0] rem_nxt;

  // bring down the top two radicand bits and try (4*root + 1)
  always_comb begin
    rem_sh = {rem_in[ati_pkg::RootW-1:0], rad_in[ati_pkg::RadW-1 -: 2]};
    trial  = {root_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_in[ati_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_in[ati_pkg::RootW-2:0], 1'b0};
    end
  end

  // radicand moves up two bits per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      root_out <= root_nxt;
      rem_out  <= rem_nxt;
    end
  end
endmodule

@@ hw/rtl/ati_cordic_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_cordic_stage: one vectoring micro-rotation of the arctangent CORDIC
// Drives y towards zero and accumulates the rotated angle.
// ----------------------------------------------------------------------------
module ati_cordic_stage (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     step,
  input  ati_pkg::lane_t lane_in,
  output ati_pkg::lane_t lane_out
);
  ati_pkg::lane_t lane_nxt;
  ati_pkg::cord_t dx;
  ati_pkg::cord_t dy;

  // arithmetic shifts round toward minus infinity
  always_comb begin
    dx = lane_in.y >>> step;
    dy = lane_in.x >>> step;
    lane_nxt = lane_in;
    if (!lane_in.zero_den) begin
      if (!lane_in.y[ati_pkg::CordW-1]) begin
        lane_nxt.x   = lane_in.x + dx;
        lane_nxt.y   = lane_in.y - dy;
        lane_nxt.acc = lane_in.acc + ati_pkg::atan_tab(step);
      end else begin
        lane_nxt.x   = lane_in.x - dx;
        lane_nxt.y   = lane_in.y + dy;
        lane_nxt.acc = lane_in.acc - ati_pkg::atan_tab(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_nxt;
    end
  end
endmodule

@@ hw/rtl/ati_tilt_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_tilt_lane: one tilt angle, atan(n / sqrt(a^2 + b^2)), fully pipelined
// Square stage, bit-per-stage root, CORDIC steps, then round and clamp.
// ----------------------------------------------------------------------------
module ati_tilt_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] num,
  input  logic signed [15:0] opa,
  input  logic signed [15:0] opb,
  output logic signed [15:0] angle
);
  localparam int RootW = ati_pkg::RootW;

  // stage 0: squares
  logic [ati_pkg::SumW-1:0] sum_r;
  logic signed [15:0]       num0_r;
  logic [31:0]              sqa;
  logic [31:0]              sqb;

  always_comb begin
    sqa = 32'($signed(opa) * $signed(opa));
    sqb = 32'($signed(opb) * $signed(opb));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= ati_pkg::SumW'(sqa) + ati_pkg::SumW'(sqb);
      num0_r <= num;
    end
  end

  // root pipeline, MSB pair first
  logic [ati_pkg::RadW-1:0]  rad   [RootW+1];
  logic [RootW-1:0]          root  [RootW+1];
  logic [RootW+1:0]          rem   [RootW+1];
  logic signed [15:0]        numd  [RootW+1];

  assign rad[0]  = {sum_r, 16'h0000};
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign numd[0] = num0_r;

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    ati_sqrt_stage u_sq (
      .clk(clk), .en(en),
      .rad_in(rad[g]), .root_in(root[g]), .rem_in(rem[g]),
      .rad_out(rad[g+1]), .root_out(root[g+1]), .rem_out(rem[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        numd[g+1] <= numd[g];
      end
    end
  end

  // CORDIC chain
  ati_pkg::lane_t lane [ati_pkg::CordicSteps+1];

  always_comb begin
    lane[0].x        = ati_pkg::cord_t'(root[RootW]);
    lane[0].y        = ati_pkg::cord_t'(numd[RootW]) <<< 8;
    lane[0].zero_den = (root[RootW] == '0);
    if (root[RootW] != '0) begin
      lane[0].acc = '0;
    end else if (numd[RootW] > 0) begin
      lane[0].acc = ati_pkg::AccFull;
    end else if (numd[RootW] < 0) begin
      lane[0].acc = -ati_pkg::AccFull;
    end else begin
      lane[0].acc = '0;
    end
  end

  for (genvar s = 0; s < ati_pkg::CordicSteps; s++) begin : g_cord
    ati_cordic_stage u_cs (
      .clk(clk), .en(en), .step(5'(s)), .lane_in(lane[s]), .lane_out(lane[s+1])
    );
  end

  // round to nearest (ties up), clamp to +-90 degrees, saturate
  ati_pkg::acc_t rnd;
  ati_pkg::acc_t lim;
  always_comb begin
    rnd = (lane[ati_pkg::CordicSteps].acc +
           (ati_pkg::acc_t'(1) <<< (ati_pkg::RoundSh - 1))) >>> ati_pkg::RoundSh;
    lim = rnd;
    if (lim > ati_pkg::OutLim)  lim = ati_pkg::OutLim;
    if (lim < -ati_pkg::OutLim) lim = -ati_pkg::OutLim;
    if (lim > 32767)            lim = 32767;
    if (lim < -32768)           lim = -32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= 16'(lim);
    end
  end
endmodule

@@ hw/rtl/accel_tilt_angles_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core: roll and pitch from one accelerometer sample
// Two parallel tilt lanes behind a valid pipeline with a global stall.
// ----------------------------------------------------------------------------
// Accepts one (x, y, z) transaction per cycle unless stalled and returns roll
// and pitch in 1/256 degree, within +-90. Data passes the square register,
// the bit-per-stage square root, the sixteen CORDIC stages and the output
// register. The pipeline advances whenever its last stage is empty or being
// taken, so a downstream stall only halts it once the output holds a result.
module accel_tilt_angles_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle
);
  localparam int Lat = 2 + ati_pkg::RootW + ati_pkg::CordicSteps;

  logic [Lat-1:0] vld_r;
  logic [Lat-1:0] vld_nxt;
  logic           en;

  assign en       = !vld_r[Lat-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[Lat-1];

  // valid bits travel with the data
  always_comb begin
    vld_nxt = {vld_r[Lat-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  ati_tilt_lane u_roll (
    .clk(clk), .en(en), .num(in_accel_y), .opa(in_accel_x), .opb(in_accel_z),
    .angle(out_roll_angle)
  );

  ati_tilt_lane u_pitch (
    .clk(clk), .en(en), .num(in_accel_x), .opa(in_accel_y), .opb(in_accel_z),
    .angle(out_pitch_angle)
  );

`ifndef SYNTH
  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_roll_angle)
      && $stable(out_pitch_angle))
    else $error("result changed under stall");
  // input is stalled only while a result waits
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("spurious input stall");
  // angles stay within +-90 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_roll_angle) <= 23040 && $signed(out_roll_angle) >= -23040
      && $signed(out_pitch_angle) <= 23040 && $signed(out_pitch_angle) >= -23040)
    else $error("angle out of range");
`endif
endmodule

@@ tb/tb_accel_tilt_angles_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles_core: self-checking bench for the tilt angle core
// Drives accelerometer samples with random gaps and output back-pressure,
// predicts roll and pitch with a behavioural CORDIC and checks every result.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles_core;

  // behavioural tilt predictor: atan(n / sqrt(a*a + b*b)) in output units
  function automatic logic signed [15:0] tilt_angle(input longint n, input longint a,
                                                    input longint b);
    longint unsigned sumsq, rad, root, bitv;
    longint x, y, acc, dx, dy, outv, lim;
    sumsq = longint'(a * a) + longint'(b * b);
    rad   = sumsq << 16;
    root  = 0;
    bitv  = 64'd1 << 62;
    while (bitv > rad) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad  = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    x   = longint'(root);
    y   = n * 256;
    acc = 0;
    if (x == 0) begin
      acc = (y > 0) ? (longint'(ati_pkg::DegRight) <<< ati_pkg::AccFrac) :
            (y < 0) ? -(longint'(ati_pkg::DegRight) <<< ati_pkg::AccFrac) : 0;
    end else begin
      for (int i = 0; i < ati_pkg::CordicSteps && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx; y = y - dy; acc = acc + longint'(ati_pkg::atan_tab(5'(i)));
        end else begin
          x = x - dx; y = y + dy; acc = acc - longint'(ati_pkg::atan_tab(5'(i)));
        end
      end
    end
    outv = (acc + (longint'(1) <<< (ati_pkg::RoundSh - 1))) >>> ati_pkg::RoundSh;
    lim  = longint'(ati_pkg::DegRight) <<< ati_pkg::AngleFracBits;
    if (outv > lim) outv = lim;
    if (outv < -lim) outv = -lim;
    if (outv > 32767) outv = 32767;
    if (outv < -32768) outv = -32768;
    return 16'(outv);
  endfunction

  // expected angle pairs, oldest first
  class angle_scoreboard;
    logic signed [15:0] roll_q[$];
    logic signed [15:0] pitch_q[$];
    int errors = 0;
    int noted = 0;

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      roll_q.push_back(tilt_angle(ay, ax, az));
      pitch_q.push_back(tilt_angle(ax, ay, az));
      noted++;
    endfunction

    function void check_angles(logic signed [15:0] roll, logic signed [15:0] pitch);
      logic signed [15:0] er, ep;
      if (roll_q.size() == 0) begin
        $error("unexpected result roll=%0d pitch=%0d", roll, pitch);
        errors++;
        return;
      end
      er = roll_q.pop_front();
      ep = pitch_q.pop_front();
      if (roll !== er) begin
        $error("roll_angle expected %0d actual %0d", er, roll);
        errors++;
      end
      if (pitch !== ep) begin
        $error("pitch_angle expected %0d actual %0d", ep, pitch);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_accel_x = 0, in_accel_y = 0, in_accel_z = 0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [15:0] out_roll_angle, out_pitch_angle;

  angle_scoreboard sb = new();
  bit sending_done = 0;
  bit hold_off = 0;
  bit long_hold = 0;

  always #2 clk = ~clk;

  accel_tilt_angles_core dut (.*);

  // send one sample, held until accepted
  task automatic send_sample(input logic [15:0] ax, ay, az);
    int gap;
    gap = (long_hold || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(ax, ay, az);
    @(negedge clk);
  endtask

  // random sample leaning towards the corners and small values
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [15:0] corner[6];
    corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h1234};
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: all zero, zero denominators, extremes
    send_sample(0, 0, 0);
    send_sample(0, 5, 0);
    send_sample(0, -5, 0);
    send_sample(7, 0, 0);
    send_sample(-7, 0, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 0, 0);
    send_sample(0, 16'h7FFF, 0);
    send_sample(0, 0, 16'h8000);
    send_sample(0, 0, 1000);
    send_sample(16'h7FFF, 16'h8000, 1);
    for (int i = 0; i < 6; i++) send_sample(corner[i], corner[5 - i], corner[(i + 2) % 6]);
    // random
    for (int i = 0; i < 1500; i++) send_sample(pick_axis(), pick_axis(), pick_axis());
    in_valid <= 0;
    sending_done = 1;
  end

  // receiver: random stalls, with one long hold-off to fill the pipeline
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    @(negedge clk);
    out_stall <= 0;
    @(negedge clk);
    forever begin
      if (!hold_off && sb.noted > 200) begin
        hold_off = 1;
        long_hold = 1;
        out_stall <= 1;
        repeat (300) @(negedge clk);
        out_stall <= 0;
        long_hold = 0;
      end else begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        if (wait_cycles > 0) begin
          out_stall <= 1;
          repeat (wait_cycles) @(negedge clk);
          out_stall <= 0;
        end
      end
      @(negedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_angles(out_roll_angle, out_pitch_angle);
  end

  // end of run
  initial begin
    wait (sending_done);
    while (sb.roll_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.roll_q.size() == 0)
      $display("accel_tilt_angles_core regression: pass");
    else
      $display("accel_tilt_angles_core regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("accel_tilt_angles_core regression: fail");
    $finish;
  end
endmodule
